>>> hw/rtl/qvdi_pkg.sv
// Shared types, constants and helper functions for the quad vertex dedup indexer.
package qvdi_pkg;

    localparam int FIELD_W     = 16;
    localparam int VNUM_W      = 10;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_FIELDS  = 3 * NUM_CORNERS;
    localparam int NUM_RESULTS = 6;
    localparam int SLOT_W      = 3;
    localparam int CORNER_W    = 2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_RESULTS - 1);

    typedef struct packed {
        logic [FIELD_W-1:0] c0_pos;
        logic [FIELD_W-1:0] c0_tex;
        logic [FIELD_W-1:0] c0_norm;
        logic [FIELD_W-1:0] c1_pos;
        logic [FIELD_W-1:0] c1_tex;
        logic [FIELD_W-1:0] c1_norm;
        logic [FIELD_W-1:0] c2_pos;
        logic [FIELD_W-1:0] c2_tex;
        logic [FIELD_W-1:0] c2_norm;
        logic [FIELD_W-1:0] c3_pos;
        logic [FIELD_W-1:0] c3_tex;
        logic [FIELD_W-1:0] c3_norm;
    } face_t;

    typedef struct packed {
        logic [VNUM_W-1:0]  vertex_number;
        logic               is_new;
        logic [FIELD_W-1:0] pos_out;
        logic [FIELD_W-1:0] tex_out;
        logic [FIELD_W-1:0] norm_out;
        logic               overflow;
        logic               last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic last_slot;
        logic out_free;
    } dp_status_t;

    // Corner visited by each result slot: two triangles 0,1,2 and 0,2,3.
    function automatic logic [CORNER_W-1:0] corner_of(input logic [SLOT_W-1:0] slot);
        logic [CORNER_W-1:0] c;
        case (slot)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/qvdi_stream_if.sv
// Valid/ready stream interface used for the face input and the result output.
interface qvdi_stream_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/qvdi_ctrl.sv
// Controller state machine that sequences face capture and the six corner lookups.
module qvdi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   face_valid,
    output logic                   face_ready,
    output qvdi_pkg::dp_cmd_t      cmd,
    input  qvdi_pkg::dp_status_t   sts
);
    import qvdi_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        face_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                face_ready = 1'b1;
                if (face_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                // A lookup completes once it is decided and the result register can take it.
                if ((sts.hit || sts.exhausted) && sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    if (sts.last_slot)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/qvdi_datapath.sv
// Datapath: corner registers, triple memory with sequential scan, and result register.
module qvdi_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int INDEX_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qvdi_pkg::dp_cmd_t      cmd,
    output qvdi_pkg::dp_status_t   sts,
    input  qvdi_pkg::face_t        face_data,
    output logic                   res_valid,
    output qvdi_pkg::result_t      res_data,
    input  logic                   res_ready
);
    import qvdi_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = INDEX_BITS;
    localparam int TW = 3 * IW;
    localparam int EW = (IW > FIELD_W) ? IW : FIELD_W;
    localparam int VW = (AW > VNUM_W) ? AW : VNUM_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);

    logic [TW-1:0]      triple_mem [MAX_VERTICES];
    logic [TW-1:0]      corner_reg [NUM_CORNERS];
    logic [TW-1:0]      corner_load [NUM_CORNERS];
    logic [FIELD_W-1:0] raw [NUM_FIELDS];
    logic [EW-1:0]      dec_ext;

    logic [TW-1:0]      rd_data_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic [CW-1:0]      addr_reg;
    logic [CW-1:0]      addr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    result_t            out_data_reg;
    result_t            out_data_next;

    logic [TW-1:0]      cur_triple;
    logic               hit;
    logic               full;
    logic               rd_en;
    logic               wr_en;
    logic [VW-1:0]      vnum_wide;
    logic [EW-1:0]      pos_ext;
    logic [EW-1:0]      tex_ext;
    logic [EW-1:0]      norm_ext;

    assign raw[0]  = face_data.c0_pos;
    assign raw[1]  = face_data.c0_tex;
    assign raw[2]  = face_data.c0_norm;
    assign raw[3]  = face_data.c1_pos;
    assign raw[4]  = face_data.c1_tex;
    assign raw[5]  = face_data.c1_norm;
    assign raw[6]  = face_data.c2_pos;
    assign raw[7]  = face_data.c2_tex;
    assign raw[8]  = face_data.c2_norm;
    assign raw[9]  = face_data.c3_pos;
    assign raw[10] = face_data.c3_tex;
    assign raw[11] = face_data.c3_norm;

    // Make each index zero-based; a zero input wraps to all ones within the index width.
    always_comb
    begin
        dec_ext = '0;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dec_ext = EW'(raw[c * 3 + j]) - EW'(1);
                corner_load[c][j * IW +: IW] = dec_ext[IW-1:0];
            end
        end
    end

    assign cur_triple = corner_reg[corner_of(slot_reg)];
    assign hit        = rd_vld_reg && (rd_data_reg == cur_triple);
    assign full       = (count_reg == MAX_COUNT);
    assign rd_en      = cmd.scan && !cmd.finish && !hit && (addr_reg < count_reg);
    assign wr_en      = cmd.finish && !hit && !full;

    assign sts.hit       = hit;
    assign sts.exhausted = (addr_reg == count_reg) && !hit;
    assign sts.last_slot = (slot_reg == LAST_SLOT);
    assign sts.out_free  = !out_vld_reg || res_ready;

    always_comb
    begin
        if (hit)
        begin
            vnum_wide = VW'(rd_addr_reg);
        end
        else if (!full)
        begin
            vnum_wide = VW'(count_reg[AW-1:0]);
        end
        else
        begin
            vnum_wide = '0;
        end
        pos_ext  = EW'(cur_triple[0 * IW +: IW]);
        tex_ext  = EW'(cur_triple[1 * IW +: IW]);
        norm_ext = EW'(cur_triple[2 * IW +: IW]);

        out_data_next.vertex_number = vnum_wide[VNUM_W-1:0];
        out_data_next.is_new        = !hit && !full;
        out_data_next.pos_out       = pos_ext[FIELD_W-1:0];
        out_data_next.tex_out       = tex_ext[FIELD_W-1:0];
        out_data_next.norm_out      = norm_ext[FIELD_W-1:0];
        out_data_next.overflow      = !hit && full;
        out_data_next.last          = (slot_reg == LAST_SLOT);
    end

    always_comb
    begin
        addr_next    = addr_reg;
        rd_vld_next  = rd_vld_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        out_vld_next = out_vld_reg;
        if (cmd.load)
        begin
            addr_next   = '0;
            rd_vld_next = 1'b0;
            slot_next   = '0;
        end
        else if (cmd.finish)
        begin
            addr_next   = '0;
            rd_vld_next = 1'b0;
            slot_next   = slot_reg + 1'b1;
        end
        else if (rd_en)
        begin
            addr_next   = addr_reg + 1'b1;
            rd_vld_next = 1'b1;
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            out_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            slot_reg    <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                corner_reg[c] <= corner_load[c];
            end
        end
        if (cmd.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            triple_mem[count_reg[AW-1:0]] <= cur_triple;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= triple_mem[addr_reg[AW-1:0]];
            rd_addr_reg <= addr_reg[AW-1:0];
        end
    end

    assign res_valid = out_vld_reg;
    assign res_data  = out_data_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance entry count by one");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res_ready) |-> !cmd.finish)
        else $error("pending result overwritten");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (addr_reg < count_reg))
        else $error("scan read beyond filled entries");

endmodule

>>> hw/rtl/quad_vertex_dedup_indexer.sv
// After a face beat is accepted, each of its six lookups scans the filled entries of the
// triple memory from entry zero until it finds the triple or runs out of entries; the scan
// reads one entry per cycle through a single registered read port. A new face beat is
// accepted only once all six lookups of the previous one have finished, and a finished
// beat waits in the result register for result ready. Reset clears the entry count and
// the handshake state;
// the triple memory is not cleared, since only entries below the count are ever read.
module quad_vertex_dedup_indexer #(
    parameter int MAX_VERTICES = 1024,
    parameter int INDEX_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    qvdi_stream_if.sink   face,
    qvdi_stream_if.source result
);
    import qvdi_pkg::*;

    // Control and status traffic between the sequencer and the datapath.
    dp_cmd_t    cmd;
    dp_status_t sts;
    logic       face_ready;
    logic       res_valid;
    result_t    res_data;

    // The controller accepts a face beat only while idle, then walks the six corner
    // slots; each slot scans the filled entries of the triple memory until it hits or runs out.
    qvdi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .face_valid (face.valid),
        .face_ready (face_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // The datapath holds the decremented corners, the triple memory, the entry count
    // and a result register, so a finished beat waits there while scanning goes on.
    qvdi_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .face_data (face.data),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (result.ready)
    );

    assign face.ready   = face_ready;
    assign result.valid = res_valid;
    assign result.data  = res_data;

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the quad vertex dedup indexer: predicted index entries versus DUT.
`timescale 1ns / 1ps

import qvdi_pkg::*;

typedef logic [3*FIELD_W-1:0] key_t;

class dedup_index_tracker;
    int unsigned capacity;
    int unsigned vnum_of[key_t];
    result_t pending_entries[$];
    int unsigned mismatches;

    function new(int unsigned cap);
        capacity   = cap;
        mismatches = 0;
    endfunction

    function int unsigned filled();
        return vnum_of.num();
    endfunction

    function string show(result_t r);
        return $sformatf("vnum=%0d new=%0b pos=%h tex=%h norm=%h ovf=%0b last=%0b",
                         r.vertex_number, r.is_new, r.pos_out, r.tex_out, r.norm_out,
                         r.overflow, r.last);
    endfunction

    // Works out the six index buffer entries of one accepted face.
    function void note_face(face_t f);
        key_t corner_key[NUM_CORNERS];
        int unsigned order[NUM_RESULTS];
        int unsigned s;
        int unsigned n;
        key_t k;
        result_t r;
        order = '{0, 1, 2, 0, 2, 3};
        // Indices go zero-based with a wrap, so a zero index turns into all ones.
        corner_key[0] = {f.c0_pos - 16'd1, f.c0_tex - 16'd1, f.c0_norm - 16'd1};
        corner_key[1] = {f.c1_pos - 16'd1, f.c1_tex - 16'd1, f.c1_norm - 16'd1};
        corner_key[2] = {f.c2_pos - 16'd1, f.c2_tex - 16'd1, f.c2_norm - 16'd1};
        corner_key[3] = {f.c3_pos - 16'd1, f.c3_tex - 16'd1, f.c3_norm - 16'd1};
        for (s = 0; s < NUM_RESULTS; s++)
        begin
            k = corner_key[order[s]];
            r = '0;
            {r.pos_out, r.tex_out, r.norm_out} = k;
            r.last = (s == NUM_RESULTS - 1);
            n = vnum_of.num();
            if (vnum_of.exists(k))
            begin
                r.vertex_number = VNUM_W'(vnum_of[k]);
            end
            else if (n < capacity)
            begin
                r.vertex_number = VNUM_W'(n);
                r.is_new        = 1'b1;
                vnum_of[k]      = n;
            end
            else
            begin
                r.overflow = 1'b1;
            end
            pending_entries.insert(pending_entries.size(), r);
        end
    endfunction

    // Compares one result beat against the oldest outstanding entry.
    function void check_entry(result_t got);
        result_t want;
        if (pending_entries.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: %s", show(got));
            return;
        end
        want = pending_entries.pop_front();
        if (got.vertex_number !== want.vertex_number || got.is_new !== want.is_new ||
            got.pos_out !== want.pos_out || got.tex_out !== want.tex_out ||
            got.norm_out !== want.norm_out || got.overflow !== want.overflow ||
            got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at %0t", $realtime);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endfunction
endclass

module testbench;

    localparam int MAX_VERTICES = 1024;
    localparam int INDEX_BITS   = FIELD_W;

    bit   clk;
    logic rst_n;

    // When set, neither side inserts idle cycles.
    bit steady_run;

    qvdi_stream_if #(.T(face_t))   face_if ();
    qvdi_stream_if #(.T(result_t)) result_if ();

    quad_vertex_dedup_indexer #(
        .MAX_VERTICES (MAX_VERTICES),
        .INDEX_BITS   (INDEX_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .face   (face_if),
        .result (result_if)
    );

    dedup_index_tracker tracker;

    // One-based corner triples already sent, reused to provoke table hits.
    key_t sent_corners[$];

    always #2 clk = ~clk;

    function automatic void remember_corner(key_t k);
        sent_corners.insert(sent_corners.size(), k);
    endfunction

    // Field value for a fresh corner. Zero is below the one-based range and must wrap
    // to all ones; the other extremes are biased in so they show up regularly.
    function automatic logic [FIELD_W-1:0] pick_index();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        else if (roll < 6)
            return '1;
        else if (roll < 8)
            return FIELD_W'(1);
        else
            return FIELD_W'($urandom_range(1, 65535));
    endfunction

    function automatic key_t fresh_corner();
        return {pick_index(), pick_index(), pick_index()};
    endfunction

    // Either a new random triple or one seen before, which the table should hit.
    function automatic key_t pick_corner(int unsigned fresh_pct);
        if (sent_corners.size() == 0 || $urandom_range(0, 99) < fresh_pct)
            return fresh_corner();
        return sent_corners[$urandom_range(0, sent_corners.size() - 1)];
    endfunction

    // Only the extreme values of each field.
    function automatic key_t extreme_corner();
        logic [FIELD_W-1:0] pool[4];
        pool = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
        return {pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                pool[$urandom_range(0, 3)]};
    endfunction

    // Drives one face beat. Called and left at a falling edge. The face is handed to
    // the predictor at the rising edge at which the handshake completes.
    task automatic send_face(key_t a, key_t b, key_t c, key_t d);
        face_t f;
        f = {a, b, c, d};
        while (!steady_run && $urandom_range(0, 99) < 33)
        begin
            face_if.valid <= 1'b0;
            @(negedge clk);
        end
        face_if.valid <= 1'b1;
        face_if.data  <= f;
        do
            @(posedge clk);
        while (!face_if.ready);
        tracker.note_face(f);
        remember_corner(a);
        remember_corner(b);
        remember_corner(c);
        remember_corner(d);
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted entry has come back.
    task automatic drain_results();
        face_if.valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_entries.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned roll;
        key_t a;
        key_t b;
        tracker          = new(MAX_VERTICES);
        rst_n            = 1'b0;
        steady_run       = 1'b0;
        face_if.valid    = 1'b0;
        face_if.data     = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed faces. A face whose corners are all the same triple: one append,
        // then five hits on entry zero.
        send_face({16'd1, 16'd1, 16'd1}, {16'd1, 16'd1, 16'd1},
                  {16'd1, 16'd1, 16'd1}, {16'd1, 16'd1, 16'd1});
        // Four distinct corners, then the same face again so every lookup hits.
        send_face({16'd1, 16'd2, 16'd3}, {16'd4, 16'd5, 16'd6},
                  {16'd7, 16'd8, 16'd9}, {16'd10, 16'd11, 16'd12});
        send_face({16'd1, 16'd2, 16'd3}, {16'd4, 16'd5, 16'd6},
                  {16'd7, 16'd8, 16'd9}, {16'd10, 16'd11, 16'd12});
        // Top of the range in every field.
        send_face({16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFF, 16'hFFFE},
                  {16'hFFFE, 16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'hFFFE, 16'hFFFF});
        // Zero indices wrap to all ones and are stored like any other value.
        send_face({16'd0, 16'd0, 16'd0}, {16'd0, 16'd0, 16'd1},
                  {16'd1, 16'd0, 16'd0}, {16'd0, 16'd1, 16'd0});
        // Triples that differ from a stored one in a single field must all miss,
        // while the last corner is an exact repeat and must hit.
        send_face({16'd4, 16'd5, 16'd7}, {16'd4, 16'd6, 16'd6},
                  {16'd5, 16'd5, 16'd6}, {16'd4, 16'd5, 16'd6});
        // Mixed extremes across fields.
        send_face({16'hFFFF, 16'd1, 16'd0}, {16'd0, 16'hFFFF, 16'd1},
                  {16'd1, 16'd0, 16'hFFFF}, {16'hFFFF, 16'hFFFF, 16'd0});
        // Corner three repeats corner one inside the same face.
        send_face({16'd100, 16'd200, 16'd300}, {16'd400, 16'd500, 16'd600},
                  {16'd700, 16'd800, 16'd900}, {16'd400, 16'd500, 16'd600});
        // Alternating bit patterns.
        send_face({16'hAAAA, 16'h5555, 16'hAAAA}, {16'h5555, 16'hAAAA, 16'h5555},
                  {16'h8000, 16'h7FFF, 16'h8001}, {16'hFFFF, 16'h0001, 16'h8000});
        // Walking one through every bit position of every field.
        for (int m = 0; m < 4; m++)
        begin
            send_face({3{16'(1) << (4 * m)}}, {3{16'(1) << (4 * m + 1)}},
                      {3{16'(1) << (4 * m + 2)}}, {3{16'(1) << (4 * m + 3)}});
        end

        drain_results();

        // Random faces. Most corners are new so the table fills up over the run and
        // lookups get long; the rest reuse earlier triples and must hit.
        for (int i = 0; i < 345; i++)
        begin
            steady_run = (i >= 120 && i < 170);
            if (i == 200)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                send_face(pick_corner(80), pick_corner(80), pick_corner(80),
                          pick_corner(80));
            end
            else if (roll < 93)
            begin
                // Degenerate faces: one or two triples spread over all corners.
                a = pick_corner(50);
                b = ($urandom_range(0, 1) == 0) ? a : pick_corner(50);
                send_face(a, b, a, b);
            end
            else
            begin
                send_face(extreme_corner(), extreme_corner(), extreme_corner(),
                          extreme_corner());
            end
        end
        steady_run = 1'b0;

        // Make sure the table is full, then keep going so misses report overflow
        // while hits on stored triples still resolve.
        while (tracker.filled() < MAX_VERTICES)
            send_face(fresh_corner(), fresh_corner(), fresh_corner(), fresh_corner());
        for (int i = 0; i < 12; i++)
            send_face(pick_corner(60), pick_corner(60), pick_corner(60), pick_corner(60));

        face_if.valid <= 1'b0;
        while (tracker.pending_entries.size() != 0)
            @(negedge clk);
        // A full-table lookup scans every entry; give a stray beat that long to show up.
        repeat (6 * (MAX_VERTICES + 2)) @(negedge clk);

        if (tracker.mismatches == 0 && tracker.pending_entries.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random back-pressure, none while the steady stretch runs.
    always @(negedge clk)
        result_if.ready <= steady_run || ($urandom_range(0, 99) >= 33);

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_entry(result_if.data);
    end

    // Several times the slowest legal run with a full table on every face.
    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
